// ===== rtl/ldpg_pkg.sv =====
// Shared types, codes and constant tables for the low-discrepancy point generator.
package ldpg_pkg;

	localparam int DEF_MAX_BASE   = 50;
	localparam int DEF_MAX_DIMS   = 20;
	localparam int DEF_MAX_DIGITS = 20;
	localparam int NBITS          = 31;
	localparam longint NUM_LIMIT  = (64'd1 << NBITS) - 64'd1;
	localparam int FIT_W          = 64 * 6;

	localparam logic [2:0] CMD_STEP      = 3'd0;
	localparam logic [2:0] CMD_LOAD_ADD  = 3'd1;
	localparam logic [2:0] CMD_LOAD_MUL  = 3'd2;
	localparam logic [2:0] CMD_LOAD_SUB  = 3'd3;
	localparam logic [2:0] CMD_LOAD_COEF = 3'd4;
	localparam logic [2:0] CMD_RESTART   = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_LONG = 2'd2;

	localparam logic [1:0] CFG_BASE_Q     = 2'd0;
	localparam logic [1:0] CFG_NUM_DIMS   = 2'd1;
	localparam logic [1:0] CFG_NUM_DIGITS = 2'd2;

	localparam logic [1:0] M_INIT = 2'd0;
	localparam logic [1:0] M_STEP = 2'd1;
	localparam logic [1:0] M_RST  = 2'd2;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [5:0]       row_index;
		logic [5:0]       col_index;
		logic [4:0]       digit_pos;
		logic [NBITS-1:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0]       coord_index;
		logic [NBITS-1:0] numerator;
		logic             last;
		logic [1:0]       status;
	} out_item_t;

	function automatic int clog_min1(int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// largest digit count with q^m inside 31 bits, capped at maxd, for every q from 2 to 63 (1 below 2)
	function automatic logic [FIT_W-1:0] fit_table(int maxd);
		logic [FIT_W-1:0] t;
		longint p;
		int m;
		t = '0;
		for (int q = 0; q < 64; q++) begin
			p = 1;
			m = 0;
			for (int k = 0; k < 31; k++) begin
				if (q >= 2 && m < maxd && p * q <= NUM_LIMIT) begin
					p = p * q;
					m = m + 1;
				end
			end
			if (m < 1) m = 1;
			t[q*6 +: 6] = 6'(m);
		end
		return t;
	endfunction

endpackage

// ===== rtl/ldpg_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module ldpg_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 6,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/ldpg_div.sv =====
// Restoring divider, one quotient bit per cycle, splits the skip count into digits.
module ldpg_div import ldpg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NBITS-1:0] dividend,
	input  logic [5:0]       divisor,
	output logic             done,
	output logic [NBITS-1:0] quo,
	output logic [5:0]       rem
);

	logic [NBITS-1:0] work_q;
	logic [5:0]       rem_q, dvs_q;
	logic [4:0]       cnt_q;
	logic             busy_q, done_q;
	logic [6:0]       trial, diff;
	logic             ge;

	assign trial = {rem_q, work_q[NBITS-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(NBITS - 1);
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[5:0] : trial[5:0];
			work_q <= {work_q[NBITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = work_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/low_discrepancy_point_generator_top.sv =====
// Niederreiter point generator over GF(q): table RAMs, digit-sum RAM and sequencer.
//
// Step: one output item per coordinate, then, unless exhausted, per changed counter digit a pass
// through the digit-sum RAM read-modify-write pipeline (coefficient, multiply and
// add table reads), then a rebuild of the numerators from the digit-sum RAM, one
// entry a cycle. Restart: the serial divider splits the value into digits, then the
// digit sums are cleared, one pass per nonzero digit and the rebuild follow; a value
// too long for the digits gets only a response. After reset the whole digit-sum RAM
// is cleared before the first item is taken.
// Loads are written straight from the input. Configuration writes are taken at any time.
module low_discrepancy_point_generator_top import ldpg_pkg::*; #(
	parameter int MAX_BASE   = DEF_MAX_BASE,
	parameter int MAX_DIMS   = DEF_MAX_DIMS,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	localparam int TBL_DEPTH = MAX_BASE * MAX_BASE;
	localparam int TBL_AW    = clog_min1(TBL_DEPTH);
	localparam int DS_DEPTH  = MAX_DIMS * MAX_DIGITS;
	localparam int DS_AW     = clog_min1(DS_DEPTH);
	localparam int CO_DEPTH  = DS_DEPTH * MAX_DIGITS;
	localparam int CO_AW     = clog_min1(CO_DEPTH);
	localparam int DM_IW     = clog_min1(MAX_DIMS);
	localparam int DG_IW     = clog_min1(MAX_DIGITS);
	localparam logic [FIT_W-1:0] FIT_VEC = fit_table(MAX_DIGITS);

	typedef enum logic [11:0] {
		S_CLR  = 12'b0000_0000_0001,
		S_IDLE = 12'b0000_0000_0010,
		S_EMIT = 12'b0000_0000_0100,
		S_DIV  = 12'b0000_0000_1000,
		S_RSEL = 12'b0000_0001_0000,
		S_SUB  = 12'b0000_0010_0000,
		S_SUBW = 12'b0000_0100_0000,
		S_PASS = 12'b0000_1000_0000,
		S_DRAIN= 12'b0001_0000_0000,
		S_REB  = 12'b0010_0000_0000,
		S_REBW = 12'b0100_0000_0000,
		S_RESP = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic [1:0] mode_q, st_q;
	logic [5:0] base_q_q;
	logic [4:0] num_dims_q, num_digits_q;
	logic [6:0] q_eff, dims_eff;
	logic [5:0] nd, nd_raw, nd_fit;

	logic [5:0]       count_q [MAX_DIGITS];
	logic [5:0]       digs_q  [MAX_DIGITS];
	logic [NBITS-1:0] num_q   [MAX_DIMS];
	logic             done_q, out_valid_q, new_nz_q, oob_sub_q;
	out_item_t        out_q;
	logic [DS_AW-1:0] clr_q;
	logic [5:0]       r_q, amt_q, pj_q, bj_q;
	logic [6:0]       ei_q, pi_q, bi_q;
	logic [DG_IW-1:0] r_idx;

	logic in_fire, can_load, wrap_all;

	// pass pipeline
	logic             v_s1, v_s2, v_s3, oob_s2, oob_s3;
	logic [DS_AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [5:0]       d_s2, mul_m;
	logic             mul_ok, add_ok;
	// rebuild pipeline
	logic             b_v_s1, b_first_s1, b_last_s1, b_zero_s1;
	logic [6:0]       b_row_s1;
	logic [NBITS-1:0] acc_q, acc_next;
	logic [37:0]      acc_prod;
	logic [5:0]       b_dval;

	// memories
	logic              tbl_ok, co_ok;
	logic [TBL_AW-1:0] tbl_waddr, mul_raddr, add_raddr, sub_raddr;
	logic [CO_AW-1:0]  co_waddr, co_raddr;
	logic [DS_AW-1:0]  ds_waddr, ds_raddr, pass_ds_addr;
	logic              ds_we;
	logic [5:0]        ds_wdata, ds_rd, co_rd, mul_rd, add_rd, sub_rd;
	logic [5:0]        sub_old, sub_new;
	logic [6:0]        sub_inc;
	logic              sub_ok;

	// divider
	logic             div_start, div_done;
	logic [NBITS-1:0] div_dividend, div_quo;
	logic [5:0]       div_rem;

	// effective configuration
	always_comb begin
		if (base_q_q < 6'd2) q_eff = 7'd2;
		else if (7'(base_q_q) > 7'(MAX_BASE)) q_eff = 7'(MAX_BASE);
		else q_eff = 7'(base_q_q);
		if (num_dims_q == 5'd0) dims_eff = 7'd1;
		else if (7'(num_dims_q) > 7'(MAX_DIMS)) dims_eff = 7'(MAX_DIMS);
		else dims_eff = 7'(num_dims_q);
		if (num_digits_q == 5'd0) nd_raw = 6'd1;
		else if (6'(num_digits_q) > 6'(MAX_DIGITS)) nd_raw = 6'(MAX_DIGITS);
		else nd_raw = 6'(num_digits_q);
		nd_fit = FIT_VEC[q_eff[5:0]*6 +: 6];
		nd     = (nd_raw < nd_fit) ? nd_raw : nd_fit;
	end

	always_comb begin
		wrap_all = 1'b1;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (6'(k) < nd && (7'(count_q[k]) + 7'd1) < q_eff) wrap_all = 1'b0;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q_q     <= 6'd2;
			num_dims_q   <= 5'd1;
			num_digits_q <= 5'd20;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BASE_Q:     base_q_q     <= cfg_data;
				CFG_NUM_DIMS:   num_dims_q   <= cfg_data[4:0];
				CFG_NUM_DIGITS: num_digits_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign r_idx     = r_q[DG_IW-1:0];

	// loads
	assign tbl_ok    = (7'(in_data.row_index) < 7'(MAX_BASE))
		&& (7'(in_data.col_index) < 7'(MAX_BASE));
	assign co_ok     = (7'(in_data.row_index) < 7'(MAX_DIMS))
		&& (6'(in_data.col_index) < 6'(MAX_DIGITS)) && (6'(in_data.digit_pos) < 6'(MAX_DIGITS));
	assign tbl_waddr = TBL_AW'(32'(in_data.row_index) * MAX_BASE + 32'(in_data.col_index));
	assign co_waddr  = CO_AW'((32'(in_data.row_index) * MAX_DIGITS + 32'(in_data.col_index))
		* MAX_DIGITS + 32'(in_data.digit_pos));

	// pass stage 0: coefficient and digit sum
	assign pass_ds_addr = DS_AW'(32'(pi_q) * MAX_DIGITS + 32'(pj_q));
	assign co_raddr     = CO_AW'((32'(pi_q) * MAX_DIGITS + 32'(pj_q)) * MAX_DIGITS + 32'(r_q));
	assign ds_raddr     = (state_q == S_REB) ? DS_AW'(32'(bi_q) * MAX_DIGITS + 32'(bj_q))
		: pass_ds_addr;
	// stage 1: multiply lookup
	assign mul_ok    = (7'(co_rd) < 7'(MAX_BASE)) && (7'(amt_q) < 7'(MAX_BASE));
	assign mul_raddr = mul_ok ? TBL_AW'(32'(co_rd) * MAX_BASE + 32'(amt_q)) : '0;
	// stage 2: add lookup
	assign mul_m     = oob_s2 ? 6'd0 : mul_rd;
	assign add_ok    = (7'(d_s2) < 7'(MAX_BASE)) && (7'(mul_m) < 7'(MAX_BASE));
	assign add_raddr = add_ok ? TBL_AW'(32'(d_s2) * MAX_BASE + 32'(mul_m)) : '0;
	// stage 3: write back, or clearing sweep
	assign ds_we    = (state_q == S_CLR) || v_s3;
	assign ds_waddr = (state_q == S_CLR) ? clr_q : idx_s3;
	assign ds_wdata = ((state_q == S_CLR) || oob_s3) ? 6'd0 : add_rd;

	// counter digit increment
	assign sub_old   = count_q[r_idx];
	assign sub_inc   = 7'(sub_old) + 7'd1;
	assign sub_new   = (sub_inc < q_eff) ? sub_inc[5:0] : 6'd0;
	assign sub_ok    = (7'(sub_new) < 7'(MAX_BASE)) && (7'(sub_old) < 7'(MAX_BASE));
	assign sub_raddr = sub_ok ? TBL_AW'(32'(sub_new) * MAX_BASE + 32'(sub_old)) : '0;

	ldpg_ram #(.DEPTH(TBL_DEPTH), .WIDTH(6)) u_add (
		.clk(clk), .we(in_fire && tbl_ok && in_data.cmd == CMD_LOAD_ADD), .waddr(tbl_waddr),
		.wdata(in_data.entry_value[5:0]), .raddr(add_raddr), .rdata(add_rd));
	ldpg_ram #(.DEPTH(TBL_DEPTH), .WIDTH(6)) u_mul (
		.clk(clk), .we(in_fire && tbl_ok && in_data.cmd == CMD_LOAD_MUL), .waddr(tbl_waddr),
		.wdata(in_data.entry_value[5:0]), .raddr(mul_raddr), .rdata(mul_rd));
	ldpg_ram #(.DEPTH(TBL_DEPTH), .WIDTH(6)) u_sub (
		.clk(clk), .we(in_fire && tbl_ok && in_data.cmd == CMD_LOAD_SUB), .waddr(tbl_waddr),
		.wdata(in_data.entry_value[5:0]), .raddr(sub_raddr), .rdata(sub_rd));
	ldpg_ram #(.DEPTH(CO_DEPTH), .WIDTH(6)) u_coeff (
		.clk(clk), .we(in_fire && co_ok && in_data.cmd == CMD_LOAD_COEF), .waddr(co_waddr),
		.wdata(in_data.entry_value[5:0]), .raddr(co_raddr), .rdata(co_rd));
	ldpg_ram #(.DEPTH(DS_DEPTH), .WIDTH(6)) u_sums (
		.clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
		.raddr(ds_raddr), .rdata(ds_rd));

	assign div_start    = (in_fire && in_data.cmd == CMD_RESTART)
		|| (state_q == S_DIV && div_done && (r_q + 6'd1) < nd);
	assign div_dividend = in_fire ? in_data.entry_value : div_quo;

	ldpg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(q_eff[5:0]), .done(div_done), .quo(div_quo), .rem(div_rem));

	always_ff @(posedge clk) begin
		if (in_fire && in_data.cmd == CMD_RESTART) begin
			for (int k = 0; k < MAX_DIGITS; k++) digs_q[k] <= '0;
		end else if (state_q == S_DIV && div_done) begin
			digs_q[r_idx] <= div_rem;
		end
	end

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			b_v_s1 <= 1'b0;
		end else begin
			v_s1   <= (state_q == S_PASS);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			b_v_s1 <= (state_q == S_REB);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= pass_ds_addr;
		idx_s2     <= idx_s1;
		d_s2       <= ds_rd;
		oob_s2     <= !mul_ok;
		idx_s3     <= idx_s2;
		oob_s3     <= !add_ok;
		b_first_s1 <= (bj_q == 6'd0);
		b_last_s1  <= (bj_q == nd - 6'd1);
		b_row_s1   <= bi_q;
		b_zero_s1  <= (bi_q >= dims_eff);
		if (b_v_s1) acc_q <= acc_next;
	end

	// numerator rebuild: acc = acc*q + digit sum, modulo 2^31
	assign b_dval   = b_zero_s1 ? 6'd0 : ds_rd;
	assign acc_prod = 38'(acc_q) * 38'(q_eff);
	assign acc_next = NBITS'((b_first_s1 ? 38'd0 : acc_prod) + 38'(b_dval));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIMS; k++) num_q[k] <= '0;
		end else if (b_v_s1 && b_last_s1) begin
			num_q[b_row_s1[DM_IW-1:0]] <= acc_next;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			mode_q      <= M_INIT;
			st_q        <= ST_OK;
			clr_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			r_q         <= '0;
			ei_q        <= '0;
			pi_q        <= '0;
			pj_q        <= '0;
			bi_q        <= '0;
			bj_q        <= '0;
			amt_q       <= '0;
			new_nz_q    <= 1'b0;
			oob_sub_q   <= 1'b0;
			for (int k = 0; k < MAX_DIGITS; k++) count_q[k] <= '0;
		end else begin
			// the emit and response states reload the output register themselves
			if (out_valid_q && !out_stall && state_q != S_EMIT && state_q != S_RESP)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (clr_q == DS_AW'(DS_DEPTH - 1)) begin
						clr_q <= '0;
						r_q   <= '0;
						state_q <= (mode_q == M_INIT) ? S_IDLE : S_RSEL;
					end else begin
						clr_q <= DS_AW'(clr_q + 1'b1);
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						case (in_data.cmd)
							CMD_STEP: begin
								mode_q  <= M_STEP;
								st_q    <= (done_q || wrap_all) ? ST_DONE : ST_OK;
								ei_q    <= '0;
								state_q <= S_EMIT;
							end
							CMD_RESTART: begin
								mode_q  <= M_RST;
								r_q     <= '0;
								state_q <= S_DIV;
							end
							default: ;
						endcase
					end
				end
				S_EMIT: begin
					if (can_load) begin
						out_q.coord_index <= 5'(ei_q);
						out_q.numerator   <= num_q[ei_q[DM_IW-1:0]];
						out_q.last        <= (ei_q == dims_eff - 7'd1);
						out_q.status      <= st_q;
						out_valid_q       <= 1'b1;
						ei_q              <= ei_q + 7'd1;
						if (ei_q == dims_eff - 7'd1) begin
							r_q     <= '0;
							state_q <= done_q ? S_IDLE : S_SUB;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						r_q <= r_q + 6'd1;
						if ((r_q + 6'd1) >= nd) begin
							if (div_quo != '0) begin
								st_q    <= ST_LONG;
								state_q <= S_RESP;
							end else begin
								st_q   <= ST_OK;
								done_q <= 1'b0;
								for (int k = 0; k < MAX_DIGITS; k++)
									count_q[k] <= (6'(k) == r_q) ? div_rem : digs_q[k];
								clr_q   <= '0;
								state_q <= S_CLR;
							end
						end
					end
				end
				S_RSEL: begin
					if (r_q >= nd) begin
						bi_q    <= '0;
						bj_q    <= '0;
						state_q <= S_REB;
					end else if (count_q[r_idx] != 6'd0) begin
						amt_q   <= count_q[r_idx];
						pi_q    <= '0;
						pj_q    <= '0;
						state_q <= S_PASS;
					end else begin
						r_q <= r_q + 6'd1;
					end
				end
				S_SUB: begin
					count_q[r_idx] <= sub_new;
					new_nz_q       <= (sub_new != 6'd0);
					oob_sub_q      <= !sub_ok;
					state_q        <= S_SUBW;
				end
				S_SUBW: begin
					amt_q   <= oob_sub_q ? 6'd0 : sub_rd;
					pi_q    <= '0;
					pj_q    <= '0;
					state_q <= S_PASS;
				end
				S_PASS: begin
					if (pj_q == nd - 6'd1) begin
						pj_q <= '0;
						pi_q <= pi_q + 7'd1;
						if (pi_q == dims_eff - 7'd1) state_q <= S_DRAIN;
					end else begin
						pj_q <= pj_q + 6'd1;
					end
				end
				S_DRAIN: begin
					// same digit sums are touched by the next pass: wait for write-back
					if (!v_s1 && !v_s2 && !v_s3) begin
						if (mode_q == M_STEP) begin
							if (new_nz_q) begin
								bi_q    <= '0;
								bj_q    <= '0;
								state_q <= S_REB;
							end else if ((r_q + 6'd1) >= nd) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								r_q     <= r_q + 6'd1;
								state_q <= S_SUB;
							end
						end else begin
							r_q     <= r_q + 6'd1;
							state_q <= S_RSEL;
						end
					end
				end
				S_REB: begin
					if (bj_q == nd - 6'd1) begin
						bj_q <= '0;
						bi_q <= bi_q + 7'd1;
						if (bi_q == 7'(MAX_DIMS - 1)) state_q <= S_REBW;
					end else begin
						bj_q <= bj_q + 6'd1;
					end
				end
				S_REBW: begin
					state_q <= (mode_q == M_STEP) ? S_IDLE : S_RESP;
				end
				S_RESP: begin
					if (can_load) begin
						out_q.coord_index <= '0;
						out_q.numerator   <= '0;
						out_q.last        <= 1'b1;
						out_q.status      <= st_q;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == S_PASS || state_q == S_DRAIN))
		else $error("digit-sum write-back outside a pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside restart split");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q == S_DRAIN && mode_q == M_STEP))
		else $error("exhausted flag set outside a step carry");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the low-discrepancy point generator top level.
`timescale 1ns / 1ps

module tb_top import ldpg_pkg::*;;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 10000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int TBL            = DEF_MAX_BASE * DEF_MAX_BASE;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	low_discrepancy_point_generator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// generator shadow state
	int fld_add [TBL];
	int fld_mul [TBL];
	int fld_sub [TBL];
	int gen_coef [DEF_MAX_DIMS*DEF_MAX_DIGITS*DEF_MAX_DIGITS];
	int ctr_dig [DEF_MAX_DIGITS];
	int dsum [DEF_MAX_DIMS*DEF_MAX_DIGITS];
	logic [NBITS-1:0] numer_next [DEF_MAX_DIMS];
	bit exhausted;
	int reg_q = 2, reg_dims = 1, reg_digits = 20;

	in_item_t  pending_items[$];
	out_item_t coords_due[$];
	int        mismatches = 0;
	int        coords_seen = 0;
	int        idle_mode = 0;
	int        hold_left = 0;
	bit        held_once = 0;
	int        quiet_cycles = 0;

	function automatic int eff_q();
		return (reg_q < 2) ? 2 : (reg_q > DEF_MAX_BASE ? DEF_MAX_BASE : reg_q);
	endfunction

	function automatic int eff_dims();
		return (reg_dims < 1) ? 1 : (reg_dims > DEF_MAX_DIMS ? DEF_MAX_DIMS : reg_dims);
	endfunction

	function automatic int eff_digits();
		int n, m, q;
		longint p;
		q = eff_q();
		n = (reg_digits < 1) ? 1 : (reg_digits > DEF_MAX_DIGITS ? DEF_MAX_DIGITS : reg_digits);
		m = 0;
		p = 1;
		while (m < DEF_MAX_DIGITS && p * q <= NUM_LIMIT) begin
			p = p * q;
			m++;
		end
		if (m < 1) m = 1;
		return (n < m) ? n : m;
	endfunction

	// q^nd: number of distinct counter values
	function automatic longint seq_length();
		longint p;
		p = 1;
		repeat (eff_digits()) p = p * eff_q();
		return p;
	endfunction

	function automatic int tab_rd(logic [2:0] which, int a, int b);
		if (a >= DEF_MAX_BASE || b >= DEF_MAX_BASE) return 0;
		case (which)
			CMD_LOAD_ADD: return fld_add[a*DEF_MAX_BASE+b];
			CMD_LOAD_MUL: return fld_mul[a*DEF_MAX_BASE+b];
			default:      return fld_sub[a*DEF_MAX_BASE+b];
		endcase
	endfunction

	function automatic void accumulate_digit(int r, int amount, int dims, int nd);
		int c, k;
		for (int i = 0; i < dims; i++)
			for (int j = 0; j < nd; j++) begin
				c = gen_coef[(i*DEF_MAX_DIGITS+j)*DEF_MAX_DIGITS+r];
				k = i*DEF_MAX_DIGITS + j;
				dsum[k] = tab_rd(CMD_LOAD_ADD, dsum[k], tab_rd(CMD_LOAD_MUL, c, amount)) & 63;
			end
	endfunction

	function automatic void rebuild_numer(int dims, int nd);
		longint acc;
		for (int i = 0; i < DEF_MAX_DIMS; i++) begin
			acc = 0;
			if (i < dims)
				for (int j = 0; j < nd; j++) acc = acc * eff_q() + dsum[i*DEF_MAX_DIGITS+j];
			numer_next[i] = acc[NBITS-1:0];
		end
	endfunction

	function automatic void predict_coords(in_item_t it);
		int q, dims, nd, r, old, diff;
		int digs [DEF_MAX_DIGITS];
		longint rest;
		logic [1:0] st;
		logic [NBITS-1:0] held [DEF_MAX_DIMS];
		out_item_t res;
		q = eff_q();
		dims = eff_dims();
		nd = eff_digits();
		case (it.cmd)
			CMD_LOAD_ADD, CMD_LOAD_MUL, CMD_LOAD_SUB: begin
				if (it.row_index < DEF_MAX_BASE && it.col_index < DEF_MAX_BASE) begin
					r = it.row_index * DEF_MAX_BASE + it.col_index;
					if (it.cmd == CMD_LOAD_ADD) fld_add[r] = it.entry_value[5:0];
					else if (it.cmd == CMD_LOAD_MUL) fld_mul[r] = it.entry_value[5:0];
					else fld_sub[r] = it.entry_value[5:0];
				end
			end
			CMD_LOAD_COEF: begin
				if (it.row_index < DEF_MAX_DIMS && it.col_index < DEF_MAX_DIGITS &&
				    it.digit_pos < DEF_MAX_DIGITS)
					gen_coef[(it.row_index*DEF_MAX_DIGITS+it.col_index)*DEF_MAX_DIGITS
					         + it.digit_pos] = it.entry_value[5:0];
			end
			CMD_RESTART: begin
				rest = longint'(it.entry_value);
				foreach (digs[k]) digs[k] = 0;
				for (r = 0; r < nd; r++) begin
					digs[r] = int'(rest % q);
					rest = rest / q;
				end
				if (rest != 0) begin
					st = ST_LONG;
				end else begin
					st = ST_OK;
					ctr_dig = digs;
					foreach (dsum[k]) dsum[k] = 0;
					for (r = 0; r < nd; r++)
						if (ctr_dig[r] != 0) accumulate_digit(r, ctr_dig[r], dims, nd);
					rebuild_numer(dims, nd);
					exhausted = 0;
				end
				res = '{coord_index: '0, numerator: '0, last: 1'b1, status: st};
				coords_due.push_back(res);
			end
			CMD_STEP: begin
				st = exhausted ? ST_DONE : ST_OK;
				held = numer_next;
				if (!exhausted) begin
					r = 0;
					forever begin
						if (r >= nd) begin
							exhausted = 1;
							st = ST_DONE;
							break;
						end
						old = ctr_dig[r];
						ctr_dig[r] = (old + 1 < q) ? old + 1 : 0;
						diff = tab_rd(CMD_LOAD_SUB, ctr_dig[r], old);
						accumulate_digit(r, diff, dims, nd);
						if (ctr_dig[r] != 0) break;
						r++;
					end
					if (!exhausted) rebuild_numer(dims, nd);
				end
				for (int i = 0; i < dims; i++) begin
					res.coord_index = i[4:0];
					res.numerator = held[i];
					res.last = (i + 1 == dims);
					res.status = st;
					coords_due.push_back(res);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic bit idle_roll(bit sender);
		int pct;
		case (idle_mode)
			0: pct = sender ? 12 : 61;
			1: pct = sender ? 61 : 12;
			default: pct = 0;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) predict_coords(in_data);
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_items.size() > 0 && !idle_roll(1)) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && !out_stall) begin
			coords_seen++;
			if (coords_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected coord %p", out_data);
			end else begin
				want = coords_due.pop_front();
				if (out_data.coord_index !== want.coord_index || out_data.numerator !== want.numerator
				    || out_data.last !== want.last || out_data.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10) $display("coord mismatch: expected %p actual %p", want, out_data);
				end
			end
		end
		// one long hold-off while the input side keeps pushing
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (idle_mode == 2 && !held_once && out_valid) begin
			held_once <= 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_roll(0);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic in_item_t mk_item(logic [2:0] c, int row, int col, int pos, longint val);
		in_item_t it;
		it.cmd = c;
		it.row_index = row[5:0];
		it.col_index = col[5:0];
		it.digit_pos = pos[4:0];
		it.entry_value = val[NBITS-1:0];
		return it;
	endfunction

	function automatic in_item_t step_item();
		return mk_item(CMD_STEP, $urandom, $urandom, $urandom, $urandom);
	endfunction

	function automatic longint tbl_value();
		longint v;
		v = $urandom & NUM_LIMIT;
		v[5:0] = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 49));
		return v;
	endfunction

	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid && coords_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[5:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BASE_Q:     reg_q = val & 63;
			CFG_NUM_DIMS:   reg_dims = val & 31;
			CFG_NUM_DIGITS: reg_digits = val & 31;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int q, int dims, int digits);
		drain();
		cfg_write(CFG_BASE_Q, q);
		cfg_write(CFG_NUM_DIMS, dims);
		cfg_write(CFG_NUM_DIGITS, digits);
	endtask

	task automatic random_items(int n);
		int k;
		longint cap;
		cap = seq_length();
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, $urandom_range(0, int'(cap - 1))));
		repeat (n) begin
			k = $urandom_range(0, 99);
			if (k < 78)
				pending_items.push_back(step_item());
			else if (k < 84)
				pending_items.push_back(mk_item(CMD_RESTART, $urandom, $urandom, $urandom,
				    $urandom_range(0, int'(cap - 1))));
			else if (k < 87)
				// near the end of the sequence so that it runs out
				pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0,
				    cap - 1 - $urandom_range(0, 3) % cap));
			else if (k < 90)
				pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0,
				    cap + ($urandom % (NUM_LIMIT - cap + 1))));
			else if (k < 97)
				pending_items.push_back(mk_item(3'($urandom_range(1, 4)), $urandom_range(0, 63),
				    $urandom_range(0, 63), $urandom_range(0, 31), tbl_value()));
			else
				pending_items.push_back(mk_item(3'($urandom_range(6, 7)), $urandom, $urandom,
				    $urandom, $urandom));
		end
	endtask

	initial begin
		longint cap;
		foreach (ctr_dig[k]) ctr_dig[k] = 0;
		foreach (dsum[k]) dsum[k] = 0;
		foreach (numer_next[k]) numer_next[k] = '0;
		foreach (fld_add[k]) begin
			fld_add[k] = 0;
			fld_mul[k] = 0;
			fld_sub[k] = 0;
		end
		foreach (gen_coef[k]) gen_coef[k] = 0;
		exhausted = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fill every table and coefficient entry so no read hits an unwritten one
		for (int a = 0; a < DEF_MAX_BASE; a++)
			for (int b = 0; b < DEF_MAX_BASE; b++) begin
				pending_items.push_back(mk_item(CMD_LOAD_ADD, a, b, $urandom, tbl_value()));
				pending_items.push_back(mk_item(CMD_LOAD_MUL, a, b, $urandom, tbl_value()));
				pending_items.push_back(mk_item(CMD_LOAD_SUB, a, b, $urandom, tbl_value()));
			end
		for (int d = 0; d < DEF_MAX_DIMS; d++)
			for (int j = 0; j < DEF_MAX_DIGITS; j++)
				for (int r = 0; r < DEF_MAX_DIGITS; r++)
					pending_items.push_back(mk_item(CMD_LOAD_COEF, d, j, r, tbl_value()));

		// directed, reset configuration: q=2, one dim, 20 digits
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, 0));
		pending_items.push_back(mk_item(CMD_STEP, 63, 63, 31, NUM_LIMIT));
		pending_items.push_back(mk_item(CMD_STEP, 0, 0, 0, 0));
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, (1 << 20) - 1));
		pending_items.push_back(step_item());
		pending_items.push_back(step_item());
		pending_items.push_back(step_item());
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, 1 << 20));
		pending_items.push_back(mk_item(CMD_RESTART, 63, 63, 31, NUM_LIMIT));
		pending_items.push_back(mk_item(CMD_LOAD_ADD, 63, 0, 0, 5));
		pending_items.push_back(mk_item(CMD_LOAD_MUL, 0, 50, 0, 5));
		pending_items.push_back(mk_item(CMD_LOAD_SUB, 50, 63, 0, 5));
		pending_items.push_back(mk_item(CMD_LOAD_COEF, 20, 0, 0, 5));
		pending_items.push_back(mk_item(CMD_LOAD_COEF, 0, 20, 31, 5));
		pending_items.push_back(mk_item(3'd6, 1, 2, 3, 4));
		pending_items.push_back(mk_item(3'd7, 63, 63, 31, NUM_LIMIT));
		pending_items.push_back(step_item());

		// register values above the clamps: q 50, 20 dims, 5 digits
		set_config(63, 31, 31);
		cap = seq_length();
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, cap - 1));
		pending_items.push_back(step_item());
		pending_items.push_back(step_item());
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, cap - 2));
		pending_items.push_back(step_item());
		pending_items.push_back(step_item());

		// base drops under the counter digits without a restart
		set_config(3, 2, 4);
		repeat (4) pending_items.push_back(step_item());

		// zero registers clamp to q=2, one dim, one digit
		set_config(0, 0, 0);
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, 1));
		pending_items.push_back(step_item());
		pending_items.push_back(step_item());
		pending_items.push_back(mk_item(CMD_RESTART, 0, 0, 0, 2));

		for (int ph = 0; ph < 3; ph++) begin
			for (int s = 0; s < 2; s++) begin
				set_config(($urandom_range(0, 3) == 0) ? 2 : $urandom_range(2, 50),
				    $urandom_range(1, 5), $urandom_range(1, 31));
				idle_mode = ph;
				random_items(80);
			end
		end

		drain();
		if (coords_due.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
